// ----- sv/voxel_visible_face_culler_defines.svh -----
// ----------------------------------------------------------------------------
// voxel visible face culler assertion macros
// shared property wrappers, clocked on i_clk and held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef VOXEL_VISIBLE_FACE_CULLER_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_CULLER_DEFINES_SVH

// same-cycle implication
`define VVFC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vvfc assertion failed");

// next-cycle implication
`define VVFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vvfc assertion failed");

`endif

// ----- sv/vvfc_pkg.sv -----
// ----------------------------------------------------------------------------
// vvfc_pkg
// chunk geometry, codes, store interface types and face tables of the culler
// ----------------------------------------------------------------------------
`default_nettype none

package vvfc_pkg;

    localparam int SIZE_X = 16;
    localparam int SIZE_Y = 16;
    localparam int SIZE_Z = 16;

    // width of every coordinate field of a request
    localparam int CW = 4;

    localparam int BLOCK_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int BAW         = $clog2(BLOCK_DEPTH);

    localparam int NUM_FACES      = 6;
    localparam int VERTS_PER_FACE = 6;
    localparam int PLANE_DEPTH    = NUM_FACES * (2 ** (2 * CW));
    localparam int PAW            = $clog2(PLANE_DEPTH);

    localparam int CLR_LEN = (BLOCK_DEPTH > PLANE_DEPTH) ? BLOCK_DEPTH : PLANE_DEPTH;
    localparam int CLW     = $clog2(CLR_LEN);

    typedef enum logic [1:0] {
        ACT_WRITE_BLOCK = 2'd0,
        ACT_WRITE_PLANE = 2'd1,
        ACT_SCAN        = 2'd2,
        ACT_NOP         = 2'd3
    } t_action;

    localparam logic [2:0] FACE_LEFT   = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_FRONT  = 3'd2;
    localparam logic [2:0] FACE_BACK   = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    localparam logic REG_NEIGHBOR_PRESENT = 1'b0;

    typedef struct packed {
        logic           blk_we;
        logic [BAW-1:0] blk_waddr;
        logic [7:0]     blk_wdata;
        logic [BAW-1:0] blk_raddr;
        logic           pln_we;
        logic [PAW-1:0] pln_waddr;
        logic           pln_wdata;
        logic [PAW-1:0] pln_raddr;
    } t_store_req;

    typedef struct packed {
        logic           at_edge;
        logic [BAW-1:0] blk_addr;
        logic [PAW-1:0] pln_addr;
    } t_probe;

    function automatic logic [BAW-1:0] blk_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return BAW'((32'(x) * SIZE_Y + 32'(y)) * SIZE_Z + 32'(z));
    endfunction

    function automatic logic [PAW-1:0] pln_addr(input logic [2:0]    side,
                                                input logic [CW-1:0] u,
                                                input logic [CW-1:0] v);
        return PAW'({side, u, v});
    endfunction

    // {nx, ny, nz}, two bits each
    function automatic logic [5:0] face_normal(input logic [2:0] f);
        logic [5:0] n;
        unique case (f)
            FACE_LEFT:   n = {2'b11, 2'b00, 2'b00};
            FACE_RIGHT:  n = {2'b01, 2'b00, 2'b00};
            FACE_FRONT:  n = {2'b00, 2'b00, 2'b01};
            FACE_BACK:   n = {2'b00, 2'b00, 2'b11};
            FACE_TOP:    n = {2'b00, 2'b01, 2'b00};
            FACE_BOTTOM: n = {2'b00, 2'b11, 2'b00};
            default:     n = '0;
        endcase
        return n;
    endfunction

    // corner offset {dx, dy, dz} of vertex k of face f, vertex 0 in the low bits
    function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [2:0] k);
        logic [17:0] row;
        unique case (f)
            FACE_LEFT:   row = {3'b011, 3'b001, 3'b010, 3'b010, 3'b001, 3'b000};
            FACE_RIGHT:  row = {3'b110, 3'b100, 3'b111, 3'b111, 3'b100, 3'b101};
            FACE_FRONT:  row = {3'b111, 3'b101, 3'b011, 3'b011, 3'b101, 3'b001};
            FACE_BACK:   row = {3'b010, 3'b000, 3'b110, 3'b110, 3'b000, 3'b100};
            FACE_TOP:    row = {3'b110, 3'b111, 3'b010, 3'b010, 3'b111, 3'b011};
            FACE_BOTTOM: row = {3'b101, 3'b100, 3'b001, 3'b001, 3'b100, 3'b000};
            default:     row = '0;
        endcase
        return row[k*3 +: 3];
    endfunction

    function automatic logic [2:0] first_face(input logic [NUM_FACES-1:0] mask);
        logic [2:0] r;
        r = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (mask[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/vvfc_face_unit.sv -----
// ----------------------------------------------------------------------------
// vvfc_face_unit
// shared neighbour unit: one step along the face axis, edge test, store addresses
// ----------------------------------------------------------------------------
`default_nettype none

module vvfc_face_unit
    import vvfc_pkg::*;
(
    input  var logic [CW-1:0] i_x,
    input  var logic [CW-1:0] i_y,
    input  var logic [CW-1:0] i_z,
    input  var logic [2:0]    i_face,
    output t_probe            o_probe
);

    logic [1:0]    w_axis;
    logic          w_up;
    logic [31:0]   w_lim;
    logic [CW-1:0] w_c;
    logic [CW-1:0] w_nc;
    logic [CW-1:0] w_nx;
    logic [CW-1:0] w_ny;
    logic [CW-1:0] w_nz;
    logic [CW-1:0] w_u;
    logic [CW-1:0] w_v;

    always_comb begin
        unique case (i_face)
            FACE_LEFT: begin
                w_axis = 2'd0; w_up = 1'b0; w_lim = 32'(SIZE_X - 1);
            end
            FACE_RIGHT: begin
                w_axis = 2'd0; w_up = 1'b1; w_lim = 32'(SIZE_X - 1);
            end
            FACE_FRONT: begin
                w_axis = 2'd2; w_up = 1'b1; w_lim = 32'(SIZE_Z - 1);
            end
            FACE_BACK: begin
                w_axis = 2'd2; w_up = 1'b0; w_lim = 32'(SIZE_Z - 1);
            end
            FACE_TOP: begin
                w_axis = 2'd1; w_up = 1'b1; w_lim = 32'(SIZE_Y - 1);
            end
            default: begin
                w_axis = 2'd1; w_up = 1'b0; w_lim = 32'(SIZE_Y - 1);
            end
        endcase

        unique case (w_axis)
            2'd0:    w_c = i_x;
            2'd1:    w_c = i_y;
            default: w_c = i_z;
        endcase

        w_nc = w_up ? (w_c + CW'(1)) : (w_c - CW'(1));

        w_nx = (w_axis == 2'd0) ? w_nc : i_x;
        w_ny = (w_axis == 2'd1) ? w_nc : i_y;
        w_nz = (w_axis == 2'd2) ? w_nc : i_z;

        // plane coordinates of the facing cell in the neighbour chunk
        if (i_face == FACE_LEFT || i_face == FACE_RIGHT) begin
            w_u = i_y; w_v = i_z;
        end else if (i_face == FACE_FRONT || i_face == FACE_BACK) begin
            w_u = i_x; w_v = i_y;
        end else begin
            w_u = i_x; w_v = i_z;
        end

        o_probe.at_edge  = w_up ? (32'(w_c) == w_lim) : (w_c == '0);
        o_probe.blk_addr = blk_addr(w_nx, w_ny, w_nz);
        o_probe.pln_addr = pln_addr(i_face, w_u, w_v);
    end

endmodule

`default_nettype wire

// ----- sv/vvfc_store.sv -----
// ----------------------------------------------------------------------------
// vvfc_store
// block type memory and neighbour boundary planes with the clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module vvfc_store
    import vvfc_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var t_store_req i_req,
    output logic           o_busy,
    output logic [7:0]     o_blk_q,
    output logic           o_pln_q
);

    logic [7:0]     r_blk_mem [0:BLOCK_DEPTH-1];
    logic           r_pln_mem [0:PLANE_DEPTH-1];
    logic [CLW-1:0] r_clr_cnt;
    logic           r_busy;
    logic [7:0]     r_blk_q;
    logic           r_pln_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + CLW'(1);
            if (r_clr_cnt == CLW'(CLR_LEN - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (32'(r_clr_cnt) < 32'(BLOCK_DEPTH)) begin
                r_blk_mem[r_clr_cnt[BAW-1:0]] <= 8'd0;
            end
        end else if (i_req.blk_we) begin
            r_blk_mem[i_req.blk_waddr] <= i_req.blk_wdata;
        end
        r_blk_q <= r_blk_mem[i_req.blk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (32'(r_clr_cnt) < 32'(PLANE_DEPTH)) begin
                r_pln_mem[r_clr_cnt[PAW-1:0]] <= 1'b0;
            end
        end else if (i_req.pln_we) begin
            r_pln_mem[i_req.pln_waddr] <= i_req.pln_wdata;
        end
        r_pln_q <= r_pln_mem[i_req.pln_raddr];
    end

    assign o_busy  = r_busy;
    assign o_blk_q = r_blk_q;
    assign o_pln_q = r_pln_q;

endmodule

`default_nettype wire

// ----- sv/voxel_visible_face_culler.sv -----
// ----------------------------------------------------------------------------
// voxel_visible_face_culler
// chunk block store with boundary planes; a scan request emits the vertices
// of every exposed face of one block
// ----------------------------------------------------------------------------
// A block write, a boundary write or an ignored request is taken and leaves the block idle.
// A scan reads the scanned block in the request cycle, a check state tests its
// type, then the shared neighbour unit probes the six faces through the single
// read port of each store, one face a cycle, and a drain state takes the last
// probe's data. Each exposed face then gives six vertices, one a cycle while
// the output is taken; an empty or fully hidden block ends after the check or
// the probes. The slave side is not ready from the request until the last
// vertex is in the output register. After reset a clearing pass over the larger
// store depth zeroes both stores and no request is accepted meanwhile; register
// writes are taken at any time.
`default_nettype none

`include "voxel_visible_face_culler_defines.svh"

module voxel_visible_face_culler
    import vvfc_pkg::*;
(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // slave side
    input  var logic        s_axis_tvalid,
    output logic            s_axis_tready,
    // block_x[3:0] block_y[7:4] block_z[11:8] block_type[19:12] side[22:20]
    // cell_u[26:23] cell_v[30:27] zero[31]
    input  var logic [31:0] s_axis_tdata,
    // action[1:0]
    input  var logic [1:0]  s_axis_tuser,
    // master side
    output logic            m_axis_tvalid,
    input  var logic        m_axis_tready,
    // vertex_x[4:0] vertex_y[9:5] vertex_z[14:10] vertex_type[22:15]
    // normal_x[24:23] normal_y[26:25] normal_z[28:27] zero[31:29]
    output logic [31:0]     m_axis_tdata,
    // face_side[2:0]
    output logic [2:0]      m_axis_tuser,
    output logic            m_axis_tlast,
    // configuration
    input  var logic        psel,
    input  var logic        penable,
    input  var logic        pwrite,
    input  var logic [2:0]  paddr,
    input  var logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_PROBE,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_x;
    logic [CW-1:0]        r_y;
    logic [CW-1:0]        r_z;
    logic [7:0]           r_type;
    logic [2:0]           r_face;
    logic                 r_pvalid;
    logic [2:0]           r_pface;
    logic                 r_pedge;
    logic [NUM_FACES-1:0] r_mask;
    logic [2:0]           r_k;
    logic [5:0]           r_present;

    logic                 r_ovalid;
    logic [4:0]           r_vx;
    logic [4:0]           r_vy;
    logic [4:0]           r_vz;
    logic [7:0]           r_vtype;
    logic [5:0]           r_nrm;
    logic [2:0]           r_oface;
    logic                 r_olast;

    t_action              w_act;
    logic [CW-1:0]        w_bx;
    logic [CW-1:0]        w_by;
    logic [CW-1:0]        w_bz;
    logic [7:0]           w_btype;
    logic [2:0]           w_side;
    logic [CW-1:0]        w_u;
    logic [CW-1:0]        w_v;
    logic                 w_inside;
    logic                 w_plane_ok;
    logic                 w_in_acc;
    logic                 w_busy;
    logic [7:0]           w_blk_q;
    logic                 w_pln_q;
    t_store_req           w_req;
    t_probe               w_probe;
    logic                 w_exposed;
    logic [NUM_FACES-1:0] n_mask;
    logic [2:0]           w_cur_face;
    logic [NUM_FACES-1:0] w_rest;
    logic [2:0]           w_corner;
    logic                 w_slot;
    logic                 w_cfg_wr;

    assign w_act   = t_action'(s_axis_tuser);
    assign w_bx    = s_axis_tdata[3:0];
    assign w_by    = s_axis_tdata[7:4];
    assign w_bz    = s_axis_tdata[11:8];
    assign w_btype = s_axis_tdata[19:12];
    assign w_side  = s_axis_tdata[22:20];
    assign w_u     = s_axis_tdata[26:23];
    assign w_v     = s_axis_tdata[30:27];

    assign w_inside = (32'(w_bx) < 32'(SIZE_X)) && (32'(w_by) < 32'(SIZE_Y))
                   && (32'(w_bz) < 32'(SIZE_Z));

    always_comb begin
        w_plane_ok = (32'(w_side) < 32'(NUM_FACES));
        if (w_side == FACE_LEFT || w_side == FACE_RIGHT) begin
            w_plane_ok = w_plane_ok && (32'(w_u) < 32'(SIZE_Y)) && (32'(w_v) < 32'(SIZE_Z));
        end else if (w_side == FACE_FRONT || w_side == FACE_BACK) begin
            w_plane_ok = w_plane_ok && (32'(w_u) < 32'(SIZE_X)) && (32'(w_v) < 32'(SIZE_Y));
        end else begin
            w_plane_ok = w_plane_ok && (32'(w_u) < 32'(SIZE_X)) && (32'(w_v) < 32'(SIZE_Z));
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !w_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    vvfc_face_unit u_face (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .i_face  (r_face),
        .o_probe (w_probe)
    );

    always_comb begin
        w_req.blk_we    = w_in_acc && (w_act == ACT_WRITE_BLOCK) && w_inside;
        w_req.blk_waddr = blk_addr(w_bx, w_by, w_bz);
        w_req.blk_wdata = w_btype;
        // idle reads the scanned block itself, probing reads its neighbours
        w_req.blk_raddr = (r_state == S_IDLE) ? blk_addr(w_bx, w_by, w_bz) : w_probe.blk_addr;
        w_req.pln_we    = w_in_acc && (w_act == ACT_WRITE_PLANE) && w_plane_ok;
        w_req.pln_waddr = pln_addr(w_side, w_u, w_v);
        w_req.pln_wdata = (w_btype != 8'd0);
        w_req.pln_raddr = w_probe.pln_addr;
    end

    vvfc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_busy  (w_busy),
        .o_blk_q (w_blk_q),
        .o_pln_q (w_pln_q)
    );

    // face probed last cycle; read data is in the store output registers now
    assign w_exposed = r_pedge ? (!r_present[r_pface] || !w_pln_q) : (w_blk_q == 8'd0);
    assign n_mask    = r_mask | ((r_pvalid && w_exposed) ? (NUM_FACES'(1) << r_pface)
                                                        : NUM_FACES'(0));

    assign w_cur_face = first_face(r_mask);
    assign w_rest     = r_mask & ~(NUM_FACES'(1) << w_cur_face);
    assign w_corner   = face_corner(w_cur_face, r_k);
    assign w_slot     = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_face   <= '0;
            r_pvalid <= 1'b0;
            r_mask   <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // while emitting, the emit arm below decides the output valid
            if (r_ovalid && m_axis_tready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_act == ACT_SCAN) && w_inside) begin
                        r_x     <= w_bx;
                        r_y     <= w_by;
                        r_z     <= w_bz;
                        r_state <= S_CENTER;
                    end
                end
                S_CENTER: begin
                    if (w_blk_q == 8'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_type   <= w_blk_q;
                        r_face   <= '0;
                        r_mask   <= '0;
                        r_pvalid <= 1'b0;
                        r_state  <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_pvalid <= 1'b1;
                    r_pface  <= r_face;
                    r_pedge  <= w_probe.at_edge;
                    r_mask   <= n_mask;
                    r_face   <= r_face + 3'd1;
                    if (r_face == 3'(NUM_FACES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_mask   <= n_mask;
                    r_pvalid <= 1'b0;
                    r_k      <= '0;
                    r_state  <= (n_mask != '0) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_ovalid <= 1'b1;
                        r_vx     <= {1'b0, r_x} + 5'(w_corner[2]);
                        r_vy     <= {1'b0, r_y} + 5'(w_corner[1]);
                        r_vz     <= {1'b0, r_z} + 5'(w_corner[0]);
                        r_vtype  <= r_type;
                        r_nrm    <= face_normal(w_cur_face);
                        r_oface  <= w_cur_face;
                        r_olast  <= (r_k == 3'(VERTS_PER_FACE - 1)) && (w_rest == '0);
                        if (r_k == 3'(VERTS_PER_FACE - 1)) begin
                            r_k    <= '0;
                            r_mask <= w_rest;
                            if (w_rest == '0) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_nrm[1:0], r_nrm[3:2], r_nrm[5:4], r_vtype,
                            r_vz, r_vy, r_vx};
    assign m_axis_tuser  = r_oface;
    assign m_axis_tlast  = r_olast;

    // configuration register
    assign w_cfg_wr = psel && penable && pwrite && pready
                   && (paddr[2] == REG_NEIGHBOR_PRESENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (w_cfg_wr) begin
            r_present <= pwdata[5:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NEIGHBOR_PRESENT) ? {26'd0, r_present} : 32'd0;

    `VVFC_ASSERT_IMPL(a_emit_has_face, r_state == S_EMIT, r_mask != '0)
    `VVFC_ASSERT_IMPL(a_vertex_type_solid, m_axis_tvalid, r_vtype != 8'd0)
    `VVFC_ASSERT_IMPL(a_no_request_while_clearing, w_busy, !s_axis_tready)
    `VVFC_ASSERT_NEXT(a_probe_feeds_eval, r_state == S_PROBE, r_pvalid)

endmodule

`default_nettype wire

// ----- tb/voxel_face_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_face_checker
// watches the request, vertex and register channels of the face culler, keeps
// its own copy of the chunk, boundary planes and neighbour mask, works out the
// vertices of every scan and compares each vertex taken from the block
// ----------------------------------------------------------------------------
module voxel_face_checker
    import vvfc_pkg::*;
(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        s_axis_tvalid,
    input  var logic        s_axis_tready,
    input  var logic [31:0] s_axis_tdata,
    input  var logic [1:0]  s_axis_tuser,
    input  var logic        m_axis_tvalid,
    input  var logic        m_axis_tready,
    input  var logic [31:0] m_axis_tdata,
    input  var logic [2:0]  m_axis_tuser,
    input  var logic        m_axis_tlast,
    input  var logic        psel,
    input  var logic        penable,
    input  var logic        pwrite,
    input  var logic [2:0]  paddr,
    input  var logic [31:0] pwdata,
    input  var logic        pready,
    output int              o_pending,
    output int              o_fail_count
);

    localparam int PLANE_SPAN = 2 ** CW;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [4:0]        vx;
        logic [4:0]        vy;
        logic [4:0]        vz;
        logic [7:0]        vtype;
        logic signed [1:0] nx;
        logic signed [1:0] ny;
        logic signed [1:0] nz;
        logic [2:0]        face;
        logic              is_last;
    } t_vertex;

    logic [7:0] chunk [BLOCK_DEPTH];
    logic       boundary [NUM_FACES][PLANE_SPAN][PLANE_SPAN];
    logic [5:0] present;
    t_vertex    expected_vertices [$];
    int         report_count;

    function automatic int cell_idx(input int x, input int y, input int z);
        return (x * SIZE_Y + y) * SIZE_Z + z;
    endfunction

    // edge face: open when the neighbour chunk is missing or its facing cell is empty
    function automatic logic edge_open(input logic [2:0] f, input int u, input int v);
        if (!present[f]) begin
            return 1'b1;
        end
        return !boundary[f][u][v];
    endfunction

    function automatic logic face_open(input logic [2:0] f, input int x, input int y,
                                       input int z);
        case (f)
            FACE_LEFT: begin
                return (x == 0) ? edge_open(f, y, z) : (chunk[cell_idx(x - 1, y, z)] == 0);
            end
            FACE_RIGHT: begin
                return (x == SIZE_X - 1) ? edge_open(f, y, z)
                                         : (chunk[cell_idx(x + 1, y, z)] == 0);
            end
            FACE_FRONT: begin
                return (z == SIZE_Z - 1) ? edge_open(f, x, y)
                                         : (chunk[cell_idx(x, y, z + 1)] == 0);
            end
            FACE_BACK: begin
                return (z == 0) ? edge_open(f, x, y) : (chunk[cell_idx(x, y, z - 1)] == 0);
            end
            FACE_TOP: begin
                return (y == SIZE_Y - 1) ? edge_open(f, x, z)
                                         : (chunk[cell_idx(x, y + 1, z)] == 0);
            end
            default: begin
                return (y == 0) ? edge_open(f, x, z) : (chunk[cell_idx(x, y - 1, z)] == 0);
            end
        endcase
    endfunction

    // {dx, dy, dz} of vertex k, vertex 0 held in the top bits of each row
    function automatic logic [2:0] corner_offset(input logic [2:0] f, input int k);
        logic [17:0] pattern;
        case (f)
            FACE_LEFT:   pattern = {3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011};
            FACE_RIGHT:  pattern = {3'b101, 3'b100, 3'b111, 3'b111, 3'b100, 3'b110};
            FACE_FRONT:  pattern = {3'b001, 3'b101, 3'b011, 3'b011, 3'b101, 3'b111};
            FACE_BACK:   pattern = {3'b100, 3'b000, 3'b110, 3'b110, 3'b000, 3'b010};
            FACE_TOP:    pattern = {3'b011, 3'b111, 3'b010, 3'b010, 3'b111, 3'b110};
            default:     pattern = {3'b000, 3'b100, 3'b001, 3'b001, 3'b100, 3'b101};
        endcase
        return pattern[(5 - k) * 3 +: 3];
    endfunction

    function automatic string vertex_text(input t_vertex p);
        return $sformatf("pos (%0d,%0d,%0d) type %0d normal (%0d,%0d,%0d) face %0d last %0b",
                         p.vx, p.vy, p.vz, p.vtype, p.nx, p.ny, p.nz, p.face, p.is_last);
    endfunction

    task automatic expect_scan_vertices(input int x, input int y, input int z);
        t_vertex    vert;
        logic [7:0] kind;
        logic [5:0] open;
        logic [2:0] f;
        logic [2:0] off;
        int         total;
        int         n;
        kind  = chunk[cell_idx(x, y, z)];
        total = 0;
        n     = 0;
        if (kind == 0) begin
            return;
        end
        for (int i = 0; i < NUM_FACES; i++) begin
            open[i] = face_open(3'(i), x, y, z);
            if (open[i]) begin
                total += VERTS_PER_FACE;
            end
        end
        for (int i = 0; i < NUM_FACES; i++) begin
            if (open[i]) begin
                f          = 3'(i);
                vert.vtype = kind;
                vert.face  = f;
                vert.nx    = 2'sd0;
                vert.ny    = 2'sd0;
                vert.nz    = 2'sd0;
                case (f)
                    FACE_LEFT:  vert.nx = -2'sd1;
                    FACE_RIGHT: vert.nx = 2'sd1;
                    FACE_FRONT: vert.nz = 2'sd1;
                    FACE_BACK:  vert.nz = -2'sd1;
                    FACE_TOP:   vert.ny = 2'sd1;
                    default:    vert.ny = -2'sd1;
                endcase
                for (int k = 0; k < VERTS_PER_FACE; k++) begin
                    off          = corner_offset(f, k);
                    vert.vx      = 5'(x) + 5'(off[2]);
                    vert.vy      = 5'(y) + 5'(off[1]);
                    vert.vz      = 5'(z) + 5'(off[0]);
                    vert.is_last = (n == total - 1);
                    expected_vertices.push_back(vert);
                    n++;
                end
            end
        end
    endtask

    task automatic take_request();
        t_action    act;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
        logic [7:0] kind;
        logic [2:0] sd;
        logic [3:0] u;
        logic [3:0] v;
        act  = t_action'(s_axis_tuser);
        x    = s_axis_tdata[3:0];
        y    = s_axis_tdata[7:4];
        z    = s_axis_tdata[11:8];
        kind = s_axis_tdata[19:12];
        sd   = s_axis_tdata[22:20];
        u    = s_axis_tdata[26:23];
        v    = s_axis_tdata[30:27];
        case (act)
            ACT_WRITE_BLOCK: chunk[cell_idx(x, y, z)] = kind;
            ACT_WRITE_PLANE: begin
                // sides above bottom do not exist and are dropped
                if (sd < NUM_FACES) begin
                    boundary[sd][u][v] = (kind != 0);
                end
            end
            ACT_SCAN:        expect_scan_vertices(x, y, z);
            default:         ;
        endcase
    endtask

    task automatic check_vertex();
        t_vertex seen;
        t_vertex want;
        seen.vx      = m_axis_tdata[4:0];
        seen.vy      = m_axis_tdata[9:5];
        seen.vz      = m_axis_tdata[14:10];
        seen.vtype   = m_axis_tdata[22:15];
        seen.nx      = m_axis_tdata[24:23];
        seen.ny      = m_axis_tdata[26:25];
        seen.nz      = m_axis_tdata[28:27];
        seen.face    = m_axis_tuser;
        seen.is_last = m_axis_tlast;
        if (expected_vertices.size() == 0) begin
            o_fail_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("unexpected vertex: %s", vertex_text(seen));
            end
            return;
        end
        want = expected_vertices.pop_front();
        if (seen.vx != want.vx || seen.vy != want.vy || seen.vz != want.vz ||
            seen.vtype != want.vtype || seen.nx != want.nx || seen.ny != want.ny ||
            seen.nz != want.nz || seen.face != want.face || seen.is_last != want.is_last) begin
            o_fail_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("vertex mismatch: expected %s", vertex_text(want));
                $display("                 actual   %s", vertex_text(seen));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BLOCK_DEPTH; i++) begin
                chunk[i] = '0;
            end
            for (int f = 0; f < NUM_FACES; f++) begin
                for (int u = 0; u < PLANE_SPAN; u++) begin
                    for (int v = 0; v < PLANE_SPAN; v++) begin
                        boundary[f][u][v] = 1'b0;
                    end
                end
            end
            present = '0;
            expected_vertices.delete();
            o_fail_count = 0;
            report_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == {REG_NEIGHBOR_PRESENT, 2'b00}) begin
                present = pwdata[5:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_request();
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_vertex();
            end
        end
        o_pending <= expected_vertices.size();
    end

endmodule

// ----- tb/tb_voxel_visible_face_culler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_visible_face_culler
// drives block, boundary, scan and no-op requests plus neighbour mask writes into the
// face culler under varying stalls on both sides; a checker beside the block
// predicts and compares every vertex
// ----------------------------------------------------------------------------
module tb_voxel_visible_face_culler;
    import vvfc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 110;
    localparam logic [2:0] PRESENT_ADDR = {REG_NEIGHBOR_PRESENT, 2'b00};
    localparam logic [2:0] SPARE_ADDR   = {~REG_NEIGHBOR_PRESENT, 2'b00};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int fail_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int idle_cycles = 0;

    voxel_visible_face_culler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    voxel_face_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // vertex receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // coordinates cluster at the chunk edges so neighbours are often filled
    function automatic logic [3:0] hot_coord();
        if ($urandom_range(99) < 15) begin
            return 4'($urandom_range(15));
        end
        case ($urandom_range(5))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd2;
            3:       return 4'd13;
            4:       return 4'd14;
            default: return 4'd15;
        endcase
    endfunction

    function automatic logic [7:0] rand_kind();
        if ($urandom_range(2) == 0) begin
            return 8'd0;
        end
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic send_req(input t_action act, input logic [3:0] x, input logic [3:0] y,
                            input logic [3:0] z, input logic [7:0] kind,
                            input logic [2:0] sd, input logic [3:0] u, input logic [3:0] v);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, v, u, sd, kind, z, y, x};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and let every outstanding vertex drain
    task automatic wait_for_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic rand_item(output bit useful);
        int r;
        r      = $urandom_range(99);
        useful = 1'b1;
        if (r < 30) begin
            send_req(ACT_WRITE_BLOCK, hot_coord(), hot_coord(), hot_coord(), rand_kind(),
                     3'($urandom), 4'($urandom), 4'($urandom));
        end else if (r < 42) begin
            send_req(ACT_WRITE_PLANE, 4'($urandom), 4'($urandom), 4'($urandom), rand_kind(),
                     3'($urandom_range(5)), hot_coord(), hot_coord());
        end else if (r < 46) begin
            // sides beyond bottom are dropped by the block
            send_req(ACT_WRITE_PLANE, 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                     3'($urandom_range(7, 6)), 4'($urandom), 4'($urandom));
            useful = 1'b0;
        end else if (r < 49) begin
            send_req(ACT_NOP, 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                     3'($urandom), 4'($urandom), 4'($urandom));
            useful = 1'b0;
        end else begin
            send_req(ACT_SCAN, hot_coord(), hot_coord(), hot_coord(), 8'($urandom),
                     3'($urandom), 4'($urandom), 4'($urandom));
        end
    endtask

    task automatic run_phase(input int items, input bit with_hold);
        int  counted;
        bit  useful;
        counted = 0;
        if (with_hold) begin
            hold_seq <= hold_seq + 1;
        end
        while (counted < items) begin
            rand_item(useful);
            if (useful) begin
                counted++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_write(PRESENT_ADDR, 32'h0);

        // no neighbour chunks: empty scan, full cubes at both corners
        send_req(ACT_SCAN, 4'd3, 4'd3, 4'd3, 8'hFF, 3'd7, 4'hF, 4'hF);
        send_req(ACT_WRITE_BLOCK, 4'd0, 4'd0, 4'd0, 8'hFF, 3'd0, 4'd0, 4'd0);
        send_req(ACT_SCAN, 4'd0, 4'd0, 4'd0, 8'h00, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd15, 4'd15, 4'd15, 8'h01, 3'd7, 4'hF, 4'hF);
        send_req(ACT_SCAN, 4'd15, 4'd15, 4'd15, 8'hFF, 3'd7, 4'hF, 4'hF);
        send_req(ACT_NOP, 4'd7, 4'd8, 4'd9, 8'hA5, 3'd5, 4'hA, 4'h5);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'h01, 3'd6, 4'd0, 4'd0);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'hFF, 3'd7, 4'hF, 4'hF);
        // block buried on all six sides inside the chunk
        send_req(ACT_WRITE_BLOCK, 4'd5, 4'd5, 4'd5, 8'h80, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd4, 4'd5, 4'd5, 8'h11, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd6, 4'd5, 4'd5, 8'h22, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd5, 4'd4, 4'd5, 8'h33, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd5, 4'd6, 4'd5, 8'h44, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd5, 4'd5, 4'd4, 8'h55, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_BLOCK, 4'd5, 4'd5, 4'd6, 8'h66, 3'd0, 4'd0, 4'd0);
        send_req(ACT_SCAN, 4'd5, 4'd5, 4'd5, 8'h00, 3'd0, 4'd0, 4'd0);
        send_req(ACT_SCAN, 4'd4, 4'd5, 4'd5, 8'h00, 3'd0, 4'd0, 4'd0);
        wait_for_quiet();

        // every neighbour chunk present, some facing cells solid
        apb_write(PRESENT_ADDR, 32'h3F);
        apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'h01, FACE_LEFT, 4'd0, 4'd0);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'h07, FACE_BOTTOM, 4'd0, 4'd0);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'hFF, FACE_BACK, 4'd0, 4'd0);
        send_req(ACT_SCAN, 4'd0, 4'd0, 4'd0, 8'h00, 3'd0, 4'd0, 4'd0);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'h03, FACE_RIGHT, 4'd15, 4'd15);
        send_req(ACT_WRITE_PLANE, 4'd0, 4'd0, 4'd0, 8'h00, FACE_FRONT, 4'd15, 4'd15);
        send_req(ACT_SCAN, 4'd15, 4'd15, 4'd15, 8'h00, 3'd0, 4'd0, 4'd0);
        wait_for_quiet();

        tx_idle_pct = 16;
        rx_idle_pct = 59;
        apb_write(PRESENT_ADDR, $urandom());
        run_phase(ITEMS_PER_PHASE, 1'b0);
        wait_for_quiet();

        tx_idle_pct = 59;
        rx_idle_pct = 16;
        apb_write(PRESENT_ADDR, 32'($urandom_range(63)));
        run_phase(ITEMS_PER_PHASE, 1'b0);
        wait_for_quiet();

        // no idling; the receiver holds off early so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apb_write(PRESENT_ADDR, 32'($urandom_range(63)));
        run_phase(20, 1'b1);
        run_phase(ITEMS_PER_PHASE - 20, 1'b0);
        wait_for_quiet();

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/vvfc_pkg.sv
sv/vvfc_face_unit.sv
sv/vvfc_store.sv
sv/voxel_visible_face_culler.sv
tb/voxel_face_checker.sv
tb/tb_voxel_visible_face_culler.sv
